@@ src/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

   typedef enum logic [2:0] {
      KIND_ADD  = 3'd0,
      KIND_SUB  = 3'd1,
      KIND_MUL  = 3'd2,
      KIND_CDIV = 3'd3,
      KIND_RDIV = 3'd4,
      KIND_CONJ = 3'd5,
      KIND_CMP  = 3'd6
   } kind_type;

   // per-beat control that rides along the divider stages
   typedef struct packed {
      logic [2:0] kind;
      logic       neg_re;
      logic       neg_im;
      logic       ovf_re;
      logic       ovf_im;
      logic       div_zero;
      logic       equal;
   } ctrl_type;

endpackage
`default_nettype wire

@@ src/complex_arithmetic_unit_top.sv @@
// Fixed-point complex ALU: add, subtract, multiply, complex divide, divide by
// a real, conjugate and compare on signed operands of WORD_BITS bits with
// FRAC_BITS fraction bits. One beat enters per cycle and its result passes
// through the input register, the multiplier, the prep steps, the restoring
// divider (one quotient bit per stage, passed by every operation) and the
// output register. Multiply and divide results truncate toward zero, parts
// out of range saturate, and a zero divisor gives zero with div_zero set.
// A stall on the result side holds the whole pipeline.
`default_nettype none
module complex_arithmetic_unit_top #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [2:0]                  req_kind,
   input  wire logic signed [WORD_BITS-1:0] req_a_re,
   input  wire logic signed [WORD_BITS-1:0] req_a_im,
   input  wire logic signed [WORD_BITS-1:0] req_b_re,
   input  wire logic signed [WORD_BITS-1:0] req_b_im,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0]      rsp_res_re,
   output logic signed [WORD_BITS-1:0]      rsp_res_im,
   output logic                             rsp_equal,
   output logic                             rsp_div_zero,
   output logic                             rsp_saturated
);

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W + 2;
   localparam int DW  = ((2 * W > F) ? 2 * W : F) + 1;
   localparam int NW  = PW + F;
   localparam int LW  = DW + W + 1;
   localparam int RW  = (NW > LW) ? NW : LW;

   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // input register
   logic          in_valid_ff;
   logic [2:0]    in_kind_ff;
   logic [W-1:0]  in_a_re_ff, in_a_im_ff, in_b_re_ff, in_b_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_kind_ff <= req_kind;
         in_a_re_ff <= req_a_re;
         in_a_im_ff <= req_a_im;
         in_b_re_ff <= req_b_re;
         in_b_im_ff <= req_b_im;
      end
   end

   logic                  m_valid;
   logic [2:0]            m_kind;
   logic signed [W-1:0]   m_a_re, m_a_im, m_b_re, m_b_im;
   logic signed [2*W-1:0] m_rr, m_ii, m_ri, m_ir, m_bbr, m_bbi;

   cau_mul #(.W(W)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (in_valid_ff),
      .kind_in   (in_kind_ff),
      .a_re      (in_a_re_ff),
      .a_im      (in_a_im_ff),
      .b_re      (in_b_re_ff),
      .b_im      (in_b_im_ff),
      .valid_out (m_valid),
      .kind_out  (m_kind),
      .a_re_out  (m_a_re),
      .a_im_out  (m_a_im),
      .b_re_out  (m_b_re),
      .b_im_out  (m_b_im),
      .p_rr      (m_rr),
      .p_ii      (m_ii),
      .p_ri      (m_ri),
      .p_ir      (m_ir),
      .p_bbr     (m_bbr),
      .p_bbi     (m_bbi)
   );

   logic              d_valid [0:W+1];
   cau_pkg::ctrl_type d_ctrl  [0:W+1];
   logic [RW-1:0]     d_rem_re[0:W+1];
   logic [RW-1:0]     d_rem_im[0:W+1];
   logic [W:0]        d_q_re  [0:W+1];
   logic [W:0]        d_q_im  [0:W+1];
   logic [DW-1:0]     d_den   [0:W+1];

   cau_prep #(.W(W), .F(F), .DW(DW), .RW(RW)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .valid_in   (m_valid),
      .kind_in    (m_kind),
      .a_re       (m_a_re),
      .a_im       (m_a_im),
      .b_re       (m_b_re),
      .b_im       (m_b_im),
      .p_rr       (m_rr),
      .p_ii       (m_ii),
      .p_ri       (m_ri),
      .p_ir       (m_ir),
      .p_bbr      (m_bbr),
      .p_bbi      (m_bbi),
      .valid_out  (d_valid[0]),
      .ctrl_out   (d_ctrl[0]),
      .rem_re_out (d_rem_re[0]),
      .rem_im_out (d_rem_im[0]),
      .den_out    (d_den[0])
   );

   assign d_q_re[0] = '0;
   assign d_q_im[0] = '0;

   for (genvar k = 0; k <= W; k++) begin : g_div
      cau_div_step #(.W(W), .DW(DW), .RW(RW), .BIT(W - k)) u_step (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .valid_in   (d_valid[k]),
         .ctrl_in    (d_ctrl[k]),
         .rem_re_in  (d_rem_re[k]),
         .rem_im_in  (d_rem_im[k]),
         .q_re_in    (d_q_re[k]),
         .q_im_in    (d_q_im[k]),
         .den_in     (d_den[k]),
         .valid_out  (d_valid[k+1]),
         .ctrl_out   (d_ctrl[k+1]),
         .rem_re_out (d_rem_re[k+1]),
         .rem_im_out (d_rem_im[k+1]),
         .q_re_out   (d_q_re[k+1]),
         .q_im_out   (d_q_im[k+1]),
         .den_out    (d_den[k+1])
      );
   end

   // saturation and output register
   cau_pkg::ctrl_type fc;
   logic [W:0]   q_re, q_im;
   logic [W:0]   half;
   logic         have, clip_re, clip_im;
   logic [W-1:0] re_in, im_in;
   logic [W-1:0] max_v, min_v;
   logic [W-1:0] res_re_ff, res_im_ff;
   logic         eq_ff, dz_ff, sat_ff;

   always_comb begin
      fc    = d_ctrl[W+1];
      q_re  = d_q_re[W+1];
      q_im  = d_q_im[W+1];
      half  = (W+1)'(1) << (W - 1);
      max_v = {1'b0, {(W-1){1'b1}}};
      min_v = {1'b1, {(W-1){1'b0}}};
      have  = (fc.kind <= cau_pkg::KIND_CONJ) && !fc.div_zero;
      clip_re = fc.ovf_re || (fc.neg_re ? (q_re > half) : (q_re >= half));
      clip_im = fc.ovf_im || (fc.neg_im ? (q_im > half) : (q_im >= half));
      if (!have) begin
         re_in = '0;
      end else if (clip_re) begin
         re_in = fc.neg_re ? min_v : max_v;
      end else begin
         re_in = fc.neg_re ? ('0 - q_re[W-1:0]) : q_re[W-1:0];
      end
      if (!have) begin
         im_in = '0;
      end else if (clip_im) begin
         im_in = fc.neg_im ? min_v : max_v;
      end else begin
         im_in = fc.neg_im ? ('0 - q_im[W-1:0]) : q_im[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= d_valid[W+1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_re_ff <= re_in;
         res_im_ff <= im_in;
         eq_ff     <= fc.equal;
         dz_ff     <= fc.div_zero;
         sat_ff    <= have && (clip_re || clip_im);
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_res_re    = res_re_ff;
   assign rsp_res_im    = res_im_ff;
   assign rsp_equal     = eq_ff;
   assign rsp_div_zero  = dz_ff;
   assign rsp_saturated = sat_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_res_re == '0 && rsp_res_im == '0 && !rsp_saturated)
      else $error("zero divisor beat with nonzero result");

   a_eq_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal |-> !rsp_div_zero && !rsp_saturated && rsp_res_re == '0)
      else $error("compare beat carries arithmetic flags");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule
`default_nettype wire

@@ src/cau_mul.sv @@
`default_nettype none
module cau_mul #(
   parameter int W = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                valid_in,
   input  wire logic [2:0]          kind_in,
   input  wire logic signed [W-1:0] a_re,
   input  wire logic signed [W-1:0] a_im,
   input  wire logic signed [W-1:0] b_re,
   input  wire logic signed [W-1:0] b_im,
   output logic                     valid_out,
   output logic [2:0]               kind_out,
   output logic signed [W-1:0]      a_re_out,
   output logic signed [W-1:0]      a_im_out,
   output logic signed [W-1:0]      b_re_out,
   output logic signed [W-1:0]      b_im_out,
   output logic signed [2*W-1:0]    p_rr,
   output logic signed [2*W-1:0]    p_ii,
   output logic signed [2*W-1:0]    p_ri,
   output logic signed [2*W-1:0]    p_ir,
   output logic signed [2*W-1:0]    p_bbr,
   output logic signed [2*W-1:0]    p_bbi
);

   logic valid_ff;
   logic [2:0] kind_ff;
   logic signed [W-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bbr_ff, p_bbi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff  <= kind_in;
         a_re_ff  <= a_re;
         a_im_ff  <= a_im;
         b_re_ff  <= b_re;
         b_im_ff  <= b_im;
         p_rr_ff  <= a_re * b_re;
         p_ii_ff  <= a_im * b_im;
         p_ri_ff  <= a_re * b_im;
         p_ir_ff  <= a_im * b_re;
         p_bbr_ff <= b_re * b_re;
         p_bbi_ff <= b_im * b_im;
      end
   end

   assign valid_out = valid_ff;
   assign kind_out  = kind_ff;
   assign a_re_out  = a_re_ff;
   assign a_im_out  = a_im_ff;
   assign b_re_out  = b_re_ff;
   assign b_im_out  = b_im_ff;
   assign p_rr      = p_rr_ff;
   assign p_ii      = p_ii_ff;
   assign p_ri      = p_ri_ff;
   assign p_ir      = p_ir_ff;
   assign p_bbr     = p_bbr_ff;
   assign p_bbi     = p_bbi_ff;

endmodule
`default_nettype wire

@@ src/cau_prep.sv @@
`default_nettype none
module cau_prep #(
   parameter int W  = 32,
   parameter int F  = 16,
   parameter int DW = 65,
   parameter int RW = 98
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 valid_in,
   input  wire logic [2:0]           kind_in,
   input  wire logic signed [W-1:0]  a_re,
   input  wire logic signed [W-1:0]  a_im,
   input  wire logic signed [W-1:0]  b_re,
   input  wire logic signed [W-1:0]  b_im,
   input  wire logic signed [2*W-1:0] p_rr,
   input  wire logic signed [2*W-1:0] p_ii,
   input  wire logic signed [2*W-1:0] p_ri,
   input  wire logic signed [2*W-1:0] p_ir,
   input  wire logic signed [2*W-1:0] p_bbr,
   input  wire logic signed [2*W-1:0] p_bbi,
   output logic                      valid_out,
   output cau_pkg::ctrl_type         ctrl_out,
   output logic [RW-1:0]             rem_re_out,
   output logic [RW-1:0]             rem_im_out,
   output logic [DW-1:0]             den_out
);

   localparam int PW = 2 * W + 2;

   // first step: signed numerators and divisor
   logic [PW-1:0] num_re_in, num_im_in, num_re_ff, num_im_ff;
   logic [DW-1:0] den_in, den_ff, den2_ff;
   logic          dneg_in, dneg_ff, up_in, up_ff, dz_in, dz_ff, eq_in, eq_ff;
   logic [2:0]    kind_ff;
   logic          valid1_ff, valid2_ff;

   logic [PW-1:0] are_x, aim_x, bre_x, bim_x, rr_x, ii_x, ri_x, ir_x;
   logic [W-1:0]  babs;

   always_comb begin
      are_x = {{(PW-W){a_re[W-1]}}, a_re};
      aim_x = {{(PW-W){a_im[W-1]}}, a_im};
      bre_x = {{(PW-W){b_re[W-1]}}, b_re};
      bim_x = {{(PW-W){b_im[W-1]}}, b_im};
      rr_x  = {{2{p_rr[2*W-1]}}, p_rr};
      ii_x  = {{2{p_ii[2*W-1]}}, p_ii};
      ri_x  = {{2{p_ri[2*W-1]}}, p_ri};
      ir_x  = {{2{p_ir[2*W-1]}}, p_ir};
      babs  = b_re[W-1] ? (~b_re + 1'b1) : b_re;
      num_re_in = '0;
      num_im_in = '0;
      den_in    = DW'(1);
      dneg_in   = 1'b0;
      up_in     = 1'b0;
      dz_in     = 1'b0;
      eq_in     = 1'b0;
      unique case (kind_in)
         cau_pkg::KIND_ADD: begin
            num_re_in = are_x + bre_x;
            num_im_in = aim_x + bim_x;
         end
         cau_pkg::KIND_SUB: begin
            num_re_in = are_x - bre_x;
            num_im_in = aim_x - bim_x;
         end
         cau_pkg::KIND_MUL: begin
            num_re_in = rr_x - ii_x;
            num_im_in = ri_x + ir_x;
            den_in    = DW'(1) << F;
         end
         cau_pkg::KIND_CDIV: begin
            num_re_in = rr_x + ii_x;
            num_im_in = ir_x - ri_x;
            den_in    = DW'(unsigned'(p_bbr)) + DW'(unsigned'(p_bbi));
            up_in     = 1'b1;
            dz_in     = (b_re == '0) && (b_im == '0);
         end
         cau_pkg::KIND_RDIV: begin
            num_re_in = are_x;
            num_im_in = aim_x;
            den_in    = DW'(babs);
            dneg_in   = b_re[W-1];
            up_in     = 1'b1;
            dz_in     = (b_re == '0);
         end
         cau_pkg::KIND_CONJ: begin
            num_re_in = are_x;
            num_im_in = '0 - aim_x;
         end
         cau_pkg::KIND_CMP: begin
            eq_in = (a_re == b_re) && (a_im == b_im);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= valid_in;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_re_ff <= num_re_in;
         num_im_ff <= num_im_in;
         den_ff    <= den_in;
         dneg_ff   <= dneg_in;
         up_ff     <= up_in;
         dz_ff     <= dz_in;
         eq_ff     <= eq_in;
         kind_ff   <= kind_in;
      end
   end

   // second step: magnitudes, upscale and quotient range check
   logic [PW-1:0] mag_re, mag_im;
   logic [RW-1:0] rem_re_in, rem_im_in, lim;
   logic [RW-1:0] rem_re_ff, rem_im_ff;
   cau_pkg::ctrl_type ctrl_in, ctrl_ff;

   always_comb begin
      mag_re = num_re_ff[PW-1] ? ('0 - num_re_ff) : num_re_ff;
      mag_im = num_im_ff[PW-1] ? ('0 - num_im_ff) : num_im_ff;
      rem_re_in = up_ff ? (RW'(mag_re) << F) : RW'(mag_re);
      rem_im_in = up_ff ? (RW'(mag_im) << F) : RW'(mag_im);
      lim = RW'(den_ff) << (W + 1);
      ctrl_in.kind     = kind_ff;
      ctrl_in.neg_re   = num_re_ff[PW-1] ^ dneg_ff;
      ctrl_in.neg_im   = num_im_ff[PW-1] ^ dneg_ff;
      ctrl_in.ovf_re   = rem_re_in >= lim;
      ctrl_in.ovf_im   = rem_im_in >= lim;
      ctrl_in.div_zero = dz_ff;
      ctrl_in.equal    = eq_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         den2_ff   <= den_ff;
         ctrl_ff   <= ctrl_in;
      end
   end

   assign valid_out  = valid2_ff;
   assign ctrl_out   = ctrl_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign den_out    = den2_ff;

endmodule
`default_nettype wire

@@ src/cau_div_step.sv @@
`default_nettype none
module cau_div_step #(
   parameter int W   = 32,
   parameter int DW  = 65,
   parameter int RW  = 98,
   parameter int BIT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              valid_in,
   input  wire cau_pkg::ctrl_type ctrl_in,
   input  wire logic [RW-1:0]     rem_re_in,
   input  wire logic [RW-1:0]     rem_im_in,
   input  wire logic [W:0]        q_re_in,
   input  wire logic [W:0]        q_im_in,
   input  wire logic [DW-1:0]     den_in,
   output logic                   valid_out,
   output cau_pkg::ctrl_type      ctrl_out,
   output logic [RW-1:0]          rem_re_out,
   output logic [RW-1:0]          rem_im_out,
   output logic [W:0]             q_re_out,
   output logic [W:0]             q_im_out,
   output logic [DW-1:0]          den_out
);

   logic [RW-1:0] dsh;
   logic          take_re, take_im;
   logic          valid_ff;
   cau_pkg::ctrl_type ctrl_ff;
   logic [RW-1:0] rem_re_ff, rem_im_ff;
   logic [W:0]    q_re_ff, q_im_ff;
   logic [DW-1:0] den_ff;

   // one restoring step: quotient bit BIT of both parts
   always_comb begin
      dsh     = RW'(den_in) << BIT;
      take_re = rem_re_in >= dsh;
      take_im = rem_im_in >= dsh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff   <= ctrl_in;
         den_ff    <= den_in;
         rem_re_ff <= take_re ? (rem_re_in - dsh) : rem_re_in;
         rem_im_ff <= take_im ? (rem_im_in - dsh) : rem_im_in;
         q_re_ff   <= q_re_in | ((W+1)'(take_re) << BIT);
         q_im_ff   <= q_im_in | ((W+1)'(take_im) << BIT);
      end
   end

   assign valid_out  = valid_ff;
   assign ctrl_out   = ctrl_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;
   assign den_out    = den_ff;

endmodule
`default_nettype wire

@@ verif/complex_arithmetic_unit_checker.sv @@
`timescale 1ns / 1ps
module complex_arithmetic_unit_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_a_re,
   input  wire logic signed [31:0] req_a_im,
   input  wire logic signed [31:0] req_b_re,
   input  wire logic signed [31:0] req_b_im,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_res_re,
   input  wire logic signed [31:0] rsp_res_im,
   input  wire logic               rsp_equal,
   input  wire logic               rsp_div_zero,
   input  wire logic               rsp_saturated,
   output int                      fail_count,
   output int                      pending_count
);

   localparam int FRAC = 16;
   localparam logic signed [127:0] WORD_MAX = 128'sd2147483647;
   localparam logic signed [127:0] WORD_MIN = -128'sd2147483648;
   localparam logic signed [127:0] ONE_Q = 128'sd65536;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               equal;
      logic               div_zero;
      logic               saturated;
   } cplx_result_type;

   cplx_result_type expected_results[$];
   int mismatches;

   function automatic logic signed [31:0] clip_word(input logic signed [127:0] v,
                                                    inout logic clipped);
      if (v > WORD_MAX) begin
         clipped = 1'b1;
         return WORD_MAX[31:0];
      end
      if (v < WORD_MIN) begin
         clipped = 1'b1;
         return WORD_MIN[31:0];
      end
      return v[31:0];
   endfunction

   function automatic cplx_result_type compute_complex_op(
      input logic [2:0] kind, input logic signed [31:0] a_re, a_im, b_re, b_im);
      logic signed [127:0] ar, ai, br, bi, re, im, den;
      logic have;
      cplx_result_type r;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      re = 0;
      im = 0;
      have = 1'b1;
      r.equal = 1'b0;
      r.div_zero = 1'b0;
      r.saturated = 1'b0;
      case (kind)
         cau_pkg::KIND_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         cau_pkg::KIND_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         cau_pkg::KIND_MUL: begin
            re = (ar * br - ai * bi) / ONE_Q;
            im = (ar * bi + ai * br) / ONE_Q;
         end
         cau_pkg::KIND_CDIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.div_zero = 1'b1;
               have = 1'b0;
            end else begin
               re = ((ar * br + ai * bi) <<< FRAC) / den;
               im = ((ai * br - ar * bi) <<< FRAC) / den;
            end
         end
         cau_pkg::KIND_RDIV: begin
            if (br == 0) begin
               r.div_zero = 1'b1;
               have = 1'b0;
            end else begin
               re = (ar <<< FRAC) / br;
               im = (ai <<< FRAC) / br;
            end
         end
         cau_pkg::KIND_CONJ: begin
            re = ar;
            im = -ai;
         end
         cau_pkg::KIND_CMP: begin
            r.equal = (a_re == b_re) && (a_im == b_im);
            have = 1'b0;
         end
         default: have = 1'b0;
      endcase
      if (have) begin
         r.re = clip_word(re, r.saturated);
         r.im = clip_word(im, r.saturated);
      end else begin
         r.re = '0;
         r.im = '0;
      end
      return r;
   endfunction

   assign pending_count = expected_results.size();

   initial begin
      fail_count = 0;
      mismatches = 0;
   end

   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_results.push_back(compute_complex_op(req_kind, req_a_re, req_a_im,
                                                          req_b_re, req_b_im));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat re=%0d im=%0d", rsp_res_re, rsp_res_im);
            end else begin
               want = expected_results.pop_front();
               if (want.re !== rsp_res_re || want.im !== rsp_res_im ||
                   want.equal !== rsp_equal || want.div_zero !== rsp_div_zero ||
                   want.saturated !== rsp_saturated) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp re=%0d im=%0d eq=%b dz=%b sat=%b, ",
                               "got re=%0d im=%0d eq=%b dz=%b sat=%b"},
                              want.re, want.im, want.equal, want.div_zero,
                              want.saturated, rsp_res_re, rsp_res_im, rsp_equal,
                              rsp_div_zero, rsp_saturated);
               end
            end
         end
      end
   end
endmodule

@@ verif/tb_complex_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
module tb_complex_arithmetic_unit_top;

   localparam logic signed [31:0] MAXW = 32'sh7fffffff;
   localparam logic signed [31:0] MINW = 32'sh80000000;
   localparam logic signed [31:0] ONE = 32'sh00010000;
   localparam logic [2:0] KIND_NONE = 3'd7;
   localparam int RANDOM_ITEMS = 700;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [2:0] req_kind;
   logic signed [31:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic signed [31:0] rsp_res_re, rsp_res_im;
   logic rsp_equal, rsp_div_zero, rsp_saturated;
   logic quiet;
   logic long_hold;
   int fail_count, pending_count;

   complex_arithmetic_unit_top uut (.*);
   complex_arithmetic_unit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_complex_arithmetic_unit_top failed");
      $finish;
   end

   // one beat offered at the falling edge and held until taken
   task automatic send_op(input logic [2:0] kind, input logic signed [31:0] ar, ai,
                          br, bi);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_a_re = ar;
      req_a_im = ai;
      req_b_re = br;
      req_b_im = bi;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 5))
               0: return MAXW;
               1: return MINW;
               2: return 32'sd0;
               3: return ONE;
               4: return -ONE;
               default: return 32'sd1;
            endcase
         end
         1, 2: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int burst;
      logic hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (150) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready = 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            burst = $urandom_range(1, 3);
            repeat (burst) @(negedge clock);
         end else
            @(negedge clock);
      end
   end

   initial begin
      logic signed [31:0] x, y;
      logic [2:0] k;
      int waited;
      quiet = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = cau_pkg::KIND_ADD;
      req_a_re = '0;
      req_a_im = '0;
      req_b_re = '0;
      req_b_im = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_op(cau_pkg::KIND_ADD, MAXW, MINW, 32'sd1, -32'sd1);
      send_op(cau_pkg::KIND_ADD, MINW, MAXW, MINW, MAXW);
      send_op(cau_pkg::KIND_SUB, 32'sd0, MAXW, MINW, MINW);
      send_op(cau_pkg::KIND_SUB, MINW, 32'sd5, MAXW, 32'sd7);
      send_op(cau_pkg::KIND_MUL, ONE, ONE, ONE, -ONE);
      send_op(cau_pkg::KIND_MUL, MAXW, MINW, MAXW, MINW);
      send_op(cau_pkg::KIND_MUL, -32'sd3, 32'sd5, 32'sd7, -32'sd1);
      send_op(cau_pkg::KIND_CDIV, ONE, ONE, 32'sd0, 32'sd0);
      send_op(cau_pkg::KIND_CDIV, MAXW, MINW, 32'sd1, 32'sd1);
      send_op(cau_pkg::KIND_CDIV, -32'sd7, 32'sd3, ONE, -ONE);
      send_op(cau_pkg::KIND_CDIV, MINW, MINW, MINW, MINW);
      send_op(cau_pkg::KIND_RDIV, ONE, -ONE, 32'sd0, 32'sd9);
      send_op(cau_pkg::KIND_RDIV, MINW, MAXW, -32'sd1, 32'sd0);
      send_op(cau_pkg::KIND_RDIV, -32'sd7, 32'sd7, 32'sd3 * ONE, 32'sd0);
      send_op(cau_pkg::KIND_CONJ, MAXW, MINW, 32'sd0, 32'sd0);
      send_op(cau_pkg::KIND_CONJ, MINW, MAXW, 32'sd4, 32'sd4);
      send_op(cau_pkg::KIND_CMP, 32'sd12, -32'sd4, 32'sd12, -32'sd4);
      send_op(cau_pkg::KIND_CMP, 32'sd12, -32'sd4, 32'sd12, -32'sd5);
      send_op(cau_pkg::KIND_CMP, MAXW, MINW, MAXW, MINW);
      send_op(KIND_NONE, MAXW, MINW, 32'sd0, 32'sd0);
      send_op(KIND_NONE, $urandom, $urandom, $urandom, $urandom);

      // drain completely before the random part
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) long_hold = 1'b1;
         if (n == RANDOM_ITEMS - 120) quiet = 1'b1;
         k = 3'($urandom_range(0, 7));
         x = pick_operand();
         y = pick_operand();
         // divisors of zero now and then
         if ((k == cau_pkg::KIND_CDIV || k == cau_pkg::KIND_RDIV) &&
             $urandom_range(0, 7) == 0) begin
            x = '0;
            if ($urandom_range(0, 1) == 0) y = '0;
         end
         if (k == cau_pkg::KIND_CMP && $urandom_range(0, 2) == 0)
            send_op(k, x, y, x, y);
         else
            send_op(k, pick_operand(), pick_operand(), x, y);
      end
      req_valid = 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (60) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_complex_arithmetic_unit_top passed");
      else
         $display("tb_complex_arithmetic_unit_top failed");
      $finish;
   end
endmodule
